/* sv/set_assoc_cache_lru_sim_macros.svh */
// assertion macros shared by the cache simulator rtl
// expects clk and rst_n in scope at the point of use
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SACL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SACL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/sacl_pkg.sv */
// shared types, codes and widths for the set-associative cache lru simulator
// no dependencies; imported by every module of the block
package sacl_pkg;

  // default sizing
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_WAYS         = 8;
  localparam int DEF_ADDR_BITS    = 64;

  // port field widths
  localparam int ACTION_W     = 2;
  localparam int ADDRESS_W    = 64;
  localparam int OUTCOME_W    = 2;
  localparam int OUT_WAY_W    = 3;
  localparam int COUNT_W      = 32;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 6;

  // configuration register widths
  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 6;
  localparam int WAYS_CFG_W   = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD   = 2'd0,
    ACT_STORE  = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_IGNORE = 2'd3
  } action_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_META,
    ST_SCAN,
    ST_UPDATE,
    ST_REPEAT
  } state_t;

  // sequencer to way scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // way scan unit status
  typedef struct packed {
    logic hit;
    logic vacant;
  } scan_flags_t;

  // sequencer to line store
  typedef struct packed {
    logic meta_rd;
    logic meta_wr;
    logic tag_rd;
    logic tag_wr;
  } store_ctl_t;

endpackage

/* sv/sacl_store.sv */
// line store: per-set valid/recency rows and per-line tag memory
// depends on sacl_pkg; row flags mark sets never written as empty
module sacl_store
  import sacl_pkg::*;
#(
  parameter int SET_W = DEF_MAX_SET_BITS,
  parameter int WAY_W = $clog2(DEF_WAYS),
  parameter int TAG_W = DEF_ADDR_BITS,
  parameter int ROW_W = DEF_WAYS * (1 + $clog2(DEF_WAYS))
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  store_ctl_t             ctl,
  input  logic [SET_W-1:0]       meta_set,
  input  logic [ROW_W-1:0]       meta_wr_row,
  output logic [ROW_W-1:0]       meta_rd_row,
  input  logic [SET_W+WAY_W-1:0] tag_rd_addr,
  input  logic [SET_W+WAY_W-1:0] tag_wr_addr,
  input  logic [TAG_W-1:0]       tag_wr_data,
  output logic [TAG_W-1:0]       tag_rd_data
);

  localparam int NUM_SETS  = 1 << SET_W;
  localparam int NUM_LINES = 1 << (SET_W + WAY_W);

  logic [ROW_W-1:0] meta_mem [NUM_SETS];
  logic [TAG_W-1:0] tag_mem  [NUM_LINES];

  logic [NUM_SETS-1:0] row_ok_r;
  logic                row_ok_q_r;
  logic [ROW_W-1:0]    meta_q_r;
  logic [TAG_W-1:0]    tag_q_r;

  // a set never written reads as all lines invalid, rank zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r   <= '0;
      row_ok_q_r <= 1'b0;
    end else begin
      if (ctl.meta_wr) begin
        row_ok_r[meta_set] <= 1'b1;
      end
      if (ctl.meta_rd) begin
        row_ok_q_r <= row_ok_r[meta_set];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.meta_wr) begin
      meta_mem[meta_set] <= meta_wr_row;
    end
    if (ctl.meta_rd) begin
      meta_q_r <= meta_mem[meta_set];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tag_wr) begin
      tag_mem[tag_wr_addr] <= tag_wr_data;
    end
    if (ctl.tag_rd) begin
      tag_q_r <= tag_mem[tag_rd_addr];
    end
  end

  assign meta_rd_row = row_ok_q_r ? meta_q_r : '0;
  assign tag_rd_data = tag_q_r;

endmodule

/* sv/sacl_scan.sv */
// way scan unit: one tag compare and one rank compare per step
// depends on sacl_pkg; finds first hit, first empty way and lru way
module sacl_scan
  import sacl_pkg::*;
#(
  parameter int WAY_W  = $clog2(DEF_WAYS),
  parameter int RANK_W = $clog2(DEF_WAYS),
  parameter int TAG_W  = DEF_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctl_t         ctl,
  input  logic [WAY_W-1:0]  in_way,
  input  logic              in_valid,
  input  logic [RANK_W-1:0] in_rank,
  input  logic [TAG_W-1:0]  line_tag,
  input  logic [TAG_W-1:0]  look_tag,
  output scan_flags_t       flags,
  output logic [WAY_W-1:0]  hit_way,
  output logic [WAY_W-1:0]  vacant_way,
  output logic [WAY_W-1:0]  lru_way
);

  scan_flags_t       flags_r;
  logic [WAY_W-1:0]  hit_way_r;
  logic [WAY_W-1:0]  vacant_way_r;
  logic [WAY_W-1:0]  lru_way_r;
  logic [RANK_W-1:0] lru_rank_r;
  logic              match;

  assign match = in_valid && (line_tag == look_tag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (ctl.clear) begin
      flags_r <= '0;
    end else if (ctl.step) begin
      if (match) begin
        flags_r.hit <= 1'b1;
      end
      if (!in_valid) begin
        flags_r.vacant <= 1'b1;
      end
    end
  end

  // first match and first empty win; strict compare keeps lowest way on ties
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lru_way_r  <= '0;
      lru_rank_r <= '0;
    end else if (ctl.step) begin
      if (!flags_r.hit && match) begin
        hit_way_r <= in_way;
      end
      if (!flags_r.vacant && !in_valid) begin
        vacant_way_r <= in_way;
      end
      if (in_rank > lru_rank_r) begin
        lru_way_r  <= in_way;
        lru_rank_r <= in_rank;
      end
    end
  end

  assign flags      = flags_r;
  assign hit_way    = hit_way_r;
  assign vacant_way = vacant_way_r;
  assign lru_way    = lru_way_r;

endmodule

/* sv/set_assoc_cache_lru_sim.sv */
// top level of the tag-only set-associative cache simulator with true lru
// depends on sacl_pkg, sacl_store, sacl_scan and the assertion macro header
//
// usage
//   input: one trace access (in_action, in_address) per transaction, taken
//   at a rising edge with start high and busy low. load and store do one
//   lookup, modify does two (the second is always a hit), action 3 is taken
//   without leaving idle and gives nothing.
//   output: one transaction per lookup, shown for exactly one cycle with
//   out_strobe high; out_last marks the final one of an access. the counts
//   are the saturating running totals after that lookup.
//   config: cfg_valid/cfg_ready with cfg_index 0 set bits, 1 block bits,
//   2 ways in use; cfg_ready is always high. write only while idle.
// sequence
//   busy stays high through split, set read, the way scan over nw ways
//   (nw = ways in use) and write back, plus a repeat state for modify, as
//   the way scan unit compares one line per cycle. results are registered
//   from write back and repeat, the second of a modify in the next cycle.
// reset
//   synchronous, active low. config returns to 0, 0, 1, totals to zero and
//   every set reads as empty at once through per-set row flags, no sweep.
//   the receiver cannot stall; results are never held.
`include "set_assoc_cache_lru_sim_macros.svh"

module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int WAYS         = DEF_WAYS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // access channel
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [ADDRESS_W-1:0]   in_address,
  // result channel
  output logic                   out_strobe,
  output logic [OUTCOME_W-1:0]   out_outcome,
  output logic [OUT_WAY_W-1:0]   out_way,
  output logic                   out_last,
  output logic [COUNT_W-1:0]     out_hit_count,
  output logic [COUNT_W-1:0]     out_miss_count,
  output logic [COUNT_W-1:0]     out_eviction_count,
  // configuration channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int CNT_W  = $clog2(WAYS + 1);
  localparam int SB_W   = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;
  localparam int SH_W   = BLOCK_BITS_W + 1;
  localparam int ROW_W  = WAYS * (1 + RANK_W);

  // sequencer and transaction state
  state_t                 state_r, state_nxt;
  action_t                action_r;
  logic [ADDR_BITS-1:0]   addr_r;
  logic [SET_W-1:0]       set_r, set_nxt;
  logic [ADDR_BITS-1:0]   tag_r, tag_nxt;
  logic [WAY_W-1:0]       way_cnt_r;

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;
  logic [WAYS_CFG_W-1:0]   ways_r;

  // running totals
  logic [COUNT_W-1:0] hit_total_r, miss_total_r, evict_total_r;

  // result registers
  logic                 out_strobe_r;
  outcome_t             out_outcome_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic                 out_last_r;

  // store and scan hookup
  store_ctl_t            st_ctl;
  scan_ctl_t             scan_ctl;
  scan_flags_t           scan_flags;
  logic [WAY_W-1:0]      hit_way, vacant_way, lru_way;
  logic [WAY_W-1:0]      tag_rd_way;
  logic [ROW_W-1:0]      meta_row, new_row;
  logic [ADDR_BITS-1:0]  line_tag;

  // decoded row and lookup decision
  logic [WAYS-1:0]       valid_v, new_valid;
  logic [RANK_W-1:0]     rank_a [WAYS];
  logic [RANK_W-1:0]     new_rank [WAYS];
  logic [WAY_W-1:0]      pick;
  outcome_t              outcome;
  logic [RANK_W:0]       old_rank;
  logic [CNT_W-1:0]      nw;
  logic [CNT_W:0]        cnt_plus;
  logic                  scan_last;
  logic [SB_W-1:0]       sb_eff;
  logic [SET_W-1:0]      set_mask;
  logic [ADDR_BITS-1:0]  addr_sh;
  logic [SH_W-1:0]       tag_shamt;
  logic [WAY_W+OUT_WAY_W-1:0] pick_ext;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // effective ways in use: zero acts as one, clamp at WAYS
  always_comb begin
    if (ways_r == '0) begin
      nw = CNT_W'(1);
    end else if (int'(ways_r) > WAYS) begin
      nw = CNT_W'(WAYS);
    end else begin
      nw = CNT_W'(ways_r);
    end
  end

  assign cnt_plus  = (CNT_W + 1)'(way_cnt_r) + 1'b1;
  assign scan_last = (cnt_plus == {1'b0, nw});

  // address split: set index above the offset, tag above the index
  always_comb begin
    sb_eff = (int'(set_bits_r) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : SB_W'(set_bits_r);
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sb_eff));
    end
    addr_sh   = addr_r >> block_bits_r;
    set_nxt   = addr_sh[SET_W-1:0] & set_mask;
    tag_shamt = SH_W'(block_bits_r) + SH_W'(sb_eff);
    tag_nxt   = addr_r >> tag_shamt;
  end

  // unpack the valid bits and recency ranks of the current set
  always_comb begin
    valid_v = meta_row[WAYS-1:0];
    for (int v = 0; v < WAYS; v++) begin
      rank_a[v] = meta_row[WAYS + v*RANK_W +: RANK_W];
    end
  end

  // pick: first hit, else first empty way, else least recently used
  always_comb begin
    if (scan_flags.hit) begin
      pick    = hit_way;
      outcome = OUT_HIT;
    end else if (scan_flags.vacant) begin
      pick    = vacant_way;
      outcome = OUT_FILL;
    end else begin
      pick    = lru_way;
      outcome = OUT_EVICT;
    end
    pick_ext = (WAY_W + OUT_WAY_W)'(pick);
  end

  // move the picked line to most recent, age the lines that were newer
  always_comb begin
    old_rank = valid_v[pick] ? {1'b0, rank_a[pick]} : (RANK_W + 1)'(WAYS);
    new_row  = '0;
    for (int v = 0; v < WAYS; v++) begin
      new_valid[v] = valid_v[v] || (WAY_W'(v) == pick);
      if (WAY_W'(v) == pick) begin
        new_rank[v] = '0;
      end else if (valid_v[v] && ({1'b0, rank_a[v]} < old_rank)) begin
        new_rank[v] = rank_a[v] + 1'b1;
      end else begin
        new_rank[v] = rank_a[v];
      end
      new_row[WAYS + v*RANK_W +: RANK_W] = new_rank[v];
    end
    new_row[WAYS-1:0] = new_valid;
  end

  // sequencer: split, read the set, scan one way a cycle, write back, then a repeat for modify
  always_comb begin
    state_nxt  = state_r;
    scan_ctl   = '0;
    st_ctl     = '0;
    tag_rd_way = WAY_W'(cnt_plus);
    unique case (state_r)
      ST_IDLE: begin
        if (start && (action_t'(in_action) != ACT_IGNORE)) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        state_nxt = ST_META;
      end
      ST_META: begin
        st_ctl.meta_rd = 1'b1;
        st_ctl.tag_rd  = 1'b1;
        tag_rd_way     = '0;
        scan_ctl.clear = 1'b1;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        scan_ctl.step = 1'b1;
        st_ctl.tag_rd = 1'b1;
        if (scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        st_ctl.meta_wr = 1'b1;
        st_ctl.tag_wr  = 1'b1;
        state_nxt      = (action_r == ACT_MODIFY) ? ST_REPEAT : ST_IDLE;
      end
      ST_REPEAT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // per-access payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      action_r <= action_t'(in_action);
      addr_r   <= in_address[ADDR_BITS-1:0];
    end
    if (state_r == ST_SPLIT) begin
      set_r <= set_nxt;
      tag_r <= tag_nxt;
    end
    if (state_r == ST_META) begin
      way_cnt_r <= '0;
    end else if (state_r == ST_SCAN) begin
      way_cnt_r <= WAY_W'(cnt_plus);
    end
  end

  // config writes, any index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= WAYS_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SET_BITS:   set_bits_r   <= cfg_data[SET_BITS_W-1:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data[BLOCK_BITS_W-1:0];
        CFG_WAYS:       ways_r       <= cfg_data[WAYS_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // saturating totals; the second lookup of a modify is always a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r   <= '0;
      miss_total_r  <= '0;
      evict_total_r <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_UPDATE) || (state_r == ST_REPEAT);
      if (state_r == ST_UPDATE) begin
        if (scan_flags.hit) begin
          hit_total_r <= sat_inc(hit_total_r);
        end else begin
          miss_total_r <= sat_inc(miss_total_r);
        end
        if (outcome == OUT_EVICT) begin
          evict_total_r <= sat_inc(evict_total_r);
        end
      end else if (state_r == ST_REPEAT) begin
        hit_total_r <= sat_inc(hit_total_r);
      end
    end
  end

  // result payload; the repeat keeps the way from the first lookup
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_outcome_r <= outcome;
      out_way_r     <= pick_ext[OUT_WAY_W-1:0];
      out_last_r    <= (action_r != ACT_MODIFY);
    end else if (state_r == ST_REPEAT) begin
      out_outcome_r <= OUT_HIT;
      out_last_r    <= 1'b1;
    end
  end

  assign out_strobe         = out_strobe_r;
  assign out_outcome        = out_outcome_r;
  assign out_way            = out_way_r;
  assign out_last           = out_last_r;
  assign out_hit_count      = hit_total_r;
  assign out_miss_count     = miss_total_r;
  assign out_eviction_count = evict_total_r;

  sacl_store #(
    .SET_W (SET_W),
    .WAY_W (WAY_W),
    .TAG_W (ADDR_BITS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (st_ctl),
    .meta_set    (set_r),
    .meta_wr_row (new_row),
    .meta_rd_row (meta_row),
    .tag_rd_addr ({set_r, tag_rd_way}),
    .tag_wr_addr ({set_r, pick}),
    .tag_wr_data (tag_r),
    .tag_rd_data (line_tag)
  );

  sacl_scan #(
    .WAY_W  (WAY_W),
    .RANK_W (RANK_W),
    .TAG_W  (ADDR_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .in_way     (way_cnt_r),
    .in_valid   (valid_v[way_cnt_r]),
    .in_rank    (rank_a[way_cnt_r]),
    .line_tag   (line_tag),
    .look_tag   (tag_r),
    .flags      (scan_flags),
    .hit_way    (hit_way),
    .vacant_way (vacant_way),
    .lru_way    (lru_way)
  );

  `SACL_ASSERT_NXT(a_accept_starts, start && !busy && (action_t'(in_action) != ACT_IGNORE), state_r == ST_SPLIT, "accepted access did not start a lookup")
  `SACL_ASSERT_IMP(a_scan_in_range, state_r == ST_SCAN, (CNT_W + 1)'(way_cnt_r) < {1'b0, nw}, "way scan ran past the ways in use")
  `SACL_ASSERT_IMP(a_strobe_source, out_strobe, ($past(state_r) == ST_UPDATE) || ($past(state_r) == ST_REPEAT), "result strobe without a finished lookup")
  `SACL_ASSERT_IMP(a_evict_counted, out_strobe && (out_outcome == OUT_EVICT), (out_eviction_count != '0) && (out_miss_count != '0), "eviction result with zero totals")

endmodule

/* sim/tb_set_assoc_cache_lru_sim.sv */
// self-checking testbench for the tag-only set-associative cache with true lru
// depends on sacl_pkg and the set_assoc_cache_lru_sim rtl; needs no other files
// holds its own cache predictor and checks every lookup result against it
module tb_set_assoc_cache_lru_sim;
  import sacl_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 7;
  localparam int MAX_SB       = DEF_MAX_SET_BITS;
  localparam int NWAYS        = DEF_WAYS;
  localparam int NUM_SETS     = 1 << MAX_SB;
  localparam int NUM_SETUPS   = 13;
  localparam int ACC_PER_SETUP = 88;
  // settle time after the block goes idle, with a margin past the slowest lookup
  localparam int SETTLE_CYCLES = 24;
  localparam int POOL_SIZE    = 12;

  // one trace access as sent on the access channel
  typedef struct {
    action_t                action;
    logic [ADDRESS_W-1:0]   address;
  } access_t;

  // one lookup result as shown on the result channel
  typedef struct {
    outcome_t               outcome;
    logic [OUT_WAY_W-1:0]   way;
    logic                   last;
    logic [COUNT_W-1:0]     hits;
    logic [COUNT_W-1:0]     misses;
    logic [COUNT_W-1:0]     evicts;
  } lookup_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACTION_W-1:0]    in_action = '0;
  logic [ADDRESS_W-1:0]   in_address = '0;
  logic                   out_strobe;
  logic [OUTCOME_W-1:0]   out_outcome;
  logic [OUT_WAY_W-1:0]   out_way;
  logic                   out_last;
  logic [COUNT_W-1:0]     out_hit_count;
  logic [COUNT_W-1:0]     out_miss_count;
  logic [COUNT_W-1:0]     out_eviction_count;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  set_assoc_cache_lru_sim dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_address         (in_address),
    .out_strobe         (out_strobe),
    .out_outcome        (out_outcome),
    .out_way            (out_way),
    .out_last           (out_last),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // accesses waiting for the driver, lookups waiting for the monitor
  access_t pending_accesses[$];
  lookup_t expected_lookups[$];

  // predictor copy of the configuration, reset values 0, 0, 1
  int cfg_sb   = 0;
  int cfg_blk  = 0;
  int cfg_ways = 1;

  // predictor copy of the tag store and the running totals
  bit                 line_ok   [NUM_SETS][NWAYS];
  bit [ADDRESS_W-1:0] line_tag  [NUM_SETS][NWAYS];
  int                 line_rank [NUM_SETS][NWAYS];
  logic [COUNT_W-1:0] tot_hits   = '0;
  logic [COUNT_W-1:0] tot_misses = '0;
  logic [COUNT_W-1:0] tot_evicts = '0;

  // driver state
  access_t cur_access;
  int      gap_left = 0;
  bit      gaps_on  = 1'b1;

  // bookkeeping for the summary and the verdict
  int mismatches = 0;
  int n_access = 0, n_modify = 0, n_ignored = 0, n_setups = 0;
  int n_checked = 0, n_hit = 0, n_fill = 0, n_evict = 0;

  bit [ADDRESS_W-1:0] tag_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // generous fixed limit, far above the slowest legal run
  initial begin
    #(CLK_PERIOD * 700000);
    $display("simulation failed");
    $finish;
  end

  // set bits above the maximum act as the maximum
  function automatic int eff_set_bits();
    return (cfg_sb > MAX_SB) ? MAX_SB : cfg_sb;
  endfunction

  // ways 0 acts as 1, anything above the way count acts as the way count
  function automatic int eff_ways();
    return (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
  endfunction

  // one lookup: classify, update recency and tag store, queue the expectation
  task automatic predict_lookup(input logic [ADDRESS_W-1:0] addr, input logic fin);
    int sb, nw, st, pick, old, w;
    bit found;
    logic [ADDRESS_W-1:0] tg;
    lookup_t res;
    sb = eff_set_bits();
    nw = eff_ways();
    // shifts of 64 or more give zero, which covers the wide offset case
    st = int'((addr >> cfg_blk) & ((64'd1 << sb) - 64'd1));
    tg = addr >> (cfg_blk + sb);
    found = 1'b0;
    pick = 0;
    // only ways in use take part; lines beyond keep their tags and valid bits
    for (w = 0; w < nw; w++) begin
      if (!found && line_ok[st][w] && line_tag[st][w] == tg) begin
        pick = w;
        found = 1'b1;
      end
    end
    if (found) begin
      res.outcome = OUT_HIT;
      if (tot_hits != '1) tot_hits++;
    end else begin
      if (tot_misses != '1) tot_misses++;
      for (w = 0; w < nw; w++) begin
        if (!found && !line_ok[st][w]) begin
          pick = w;
          found = 1'b1;
        end
      end
      if (found) begin
        res.outcome = OUT_FILL;
      end else begin
        // least recently used = highest rank among ways in use, lowest way on ties
        res.outcome = OUT_EVICT;
        if (tot_evicts != '1) tot_evicts++;
        pick = 0;
        for (w = 1; w < nw; w++) begin
          if (line_rank[st][w] > line_rank[st][pick]) pick = w;
        end
      end
    end
    // promote the picked line to most recent, aging only lines that were newer
    old = line_ok[st][pick] ? line_rank[st][pick] : NWAYS;
    for (w = 0; w < NWAYS; w++) begin
      if (w != pick && line_ok[st][w] && line_rank[st][w] < old) line_rank[st][w]++;
    end
    line_rank[st][pick] = 0;
    line_ok[st][pick] = 1'b1;
    line_tag[st][pick] = tg;
    res.way = OUT_WAY_W'(pick);
    res.last = fin;
    res.hits = tot_hits;
    res.misses = tot_misses;
    res.evicts = tot_evicts;
    expected_lookups.push_back(res);
  endtask

  // an accepted access: modify is two lookups, ignore changes nothing
  task automatic predict_access(input access_t acc);
    n_access++;
    case (acc.action)
      ACT_IGNORE: n_ignored++;
      ACT_MODIFY: begin
        n_modify++;
        predict_lookup(acc.address, 1'b0);
        predict_lookup(acc.address, 1'b1);
      end
      default: predict_lookup(acc.address, 1'b1);
    endcase
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 14);
    return $urandom_range(20, 60);
  endfunction

  // access driver: start stays high until a transaction is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_access(cur_access);
        gap_left = gaps_on ? draw_gap() : 0;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_accesses.size() > 0) begin
        cur_access = pending_accesses.pop_front();
        in_action <= cur_access.action;
        in_address <= cur_access.address;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor: every strobe is one transaction, checked in order
  always @(posedge clk) begin : result_check
    lookup_t exp_res;
    if (rst_n && out_strobe) begin
      if (expected_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no lookup outstanding (outcome %0d way %0d)",
                   $time, out_outcome, out_way);
      end else begin
        exp_res = expected_lookups.pop_front();
        n_checked++;
        case (exp_res.outcome)
          OUT_HIT:  n_hit++;
          OUT_FILL: n_fill++;
          default:  n_evict++;
        endcase
        if (out_outcome !== exp_res.outcome || out_way !== exp_res.way ||
            out_last !== exp_res.last || out_hit_count !== exp_res.hits ||
            out_miss_count !== exp_res.misses ||
            out_eviction_count !== exp_res.evicts) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: lookup mismatch, expected outcome %0d way %0d last %0b",
                     $time, exp_res.outcome, exp_res.way, exp_res.last);
            $display("  expected totals hit %0d miss %0d evict %0d",
                     exp_res.hits, exp_res.misses, exp_res.evicts);
            $display("  got outcome %0d way %0d last %0b totals hit %0d miss %0d evict %0d",
                     out_outcome, out_way, out_last, out_hit_count, out_miss_count,
                     out_eviction_count);
          end
        end
      end
    end
  end

  // one register write on the config channel, mirrored into the predictor
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS:   cfg_sb = int'(d[SET_BITS_W-1:0]);
      CFG_BLOCK_BITS: cfg_blk = int'(d[BLOCK_BITS_W-1:0]);
      CFG_WAYS:       cfg_ways = int'(d[WAYS_CFG_W-1:0]);
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // wait until every access is taken and every lookup seen, then let the block settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_accesses.size() != 0 || start || busy || expected_lookups.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_access(input action_t act, input logic [ADDRESS_W-1:0] addr);
    access_t acc;
    acc.action = act;
    acc.address = addr;
    pending_accesses.push_back(acc);
  endtask

  initial begin : main_seq
    int p, k, r, sb, nw, st, s_sb, s_blk, s_nw;
    logic [ADDRESS_W-1:0] tg, off;
    access_t acc;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with the reset setup: one set, one way, tag is the whole address
    queue_access(ACT_LOAD, 64'h0);                     // fill of an empty way
    queue_access(ACT_LOAD, 64'h0);                     // hit
    queue_access(ACT_STORE, '1);                       // eviction, all address bits set
    queue_access(ACT_MODIFY, '1);                      // two hits
    queue_access(ACT_IGNORE, 64'h0);                   // nothing comes back
    queue_access(ACT_LOAD, 64'h0);
    queue_access(ACT_MODIFY, 64'h5555_5555_5555_5555); // miss then forced hit
    queue_access(ACT_IGNORE, '1);
    queue_access(ACT_STORE, 64'haaaa_aaaa_aaaa_aaaa);
    queue_access(ACT_LOAD, 64'haaaa_aaaa_aaaa_aaaa);
    queue_access(ACT_STORE, 64'h1);
    queue_access(ACT_MODIFY, 64'h8000_0000_0000_0000);
    queue_access(ACT_LOAD, 64'h8000_0000_0000_0000);
    gaps_on = 1'b0;
    wait_idle();

    for (p = 0; p < NUM_SETUPS; p++) begin
      case (p)
        0: begin s_sb = 2; s_blk = 4;  s_nw = 4;  end
        // offset plus index exactly 64 bits: every tag is zero
        1: begin s_sb = 6; s_blk = 58; s_nw = 8;  end
        // set bits above the maximum, ways above the way count
        2: begin s_sb = 7; s_blk = 6;  s_nw = 9;  end
        // everything at zero, ways 0 behaves as one way
        3: begin s_sb = 0; s_blk = 0;  s_nw = 0;  end
        // widest block bits and ways values
        4: begin s_sb = 3; s_blk = 63; s_nw = 15; end
        // fill eight ways, shrink to two, then widen again with the same tags
        5: begin s_sb = 1; s_blk = 2;  s_nw = 8;  end
        6: begin s_sb = 1; s_blk = 2;  s_nw = 2;  end
        7: begin s_sb = 1; s_blk = 2;  s_nw = 8;  end
        default: begin
          s_sb = $urandom_range(0, 7);
          s_blk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
          s_nw = $urandom_range(0, 15);
        end
      endcase
      write_reg(CFG_SET_BITS, CFG_DATA_W'(s_sb));
      write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(s_blk));
      write_reg(CFG_WAYS, CFG_DATA_W'(s_nw));
      n_setups++;

      // the shrink and re-widen phases keep the tags of the setup before them
      if (p < 6 || p > 7) begin
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) tag_pool[k] = {$urandom, $urandom};
      end

      sb = eff_set_bits();
      nw = eff_ways();
      gaps_on = ($urandom_range(0, 3) != 0);
      for (k = 0; k < ACC_PER_SETUP; k++) begin
        r = $urandom_range(0, 99);
        acc.action = (r < 35) ? ACT_LOAD : (r < 65) ? ACT_STORE :
                     (r < 90) ? ACT_MODIFY : ACT_IGNORE;
        if ($urandom_range(0, 99) < 12) begin
          // stray address anywhere in the space
          acc.address = {$urandom, $urandom};
        end else begin
          // a few hot sets and a tag pool a little larger than the ways, so
          // hits, fills and evictions all show up
          st = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_SETS - 1)
                                            : $urandom_range(0, 3);
          tg = tag_pool[$urandom_range(0, nw + 2)];
          off = {$urandom, $urandom} & ((64'd1 << cfg_blk) - 64'd1);
          acc.address = (tg << (cfg_blk + sb)) |
                        ((64'(st) & ((64'd1 << sb) - 64'd1)) << cfg_blk) | off;
        end
        pending_accesses.push_back(acc);
      end
      wait_idle();
    end

    $display("ran %0d accesses (%0d modify, %0d ignored) over %0d cache setups",
             n_access, n_modify, n_ignored, n_setups + 1);
    $display("checked %0d lookups: %0d hits, %0d fills, %0d evictions, %0d mismatches",
             n_checked, n_hit, n_fill, n_evict, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
